// File: rtl/lav_pkg.sv
// shared types and constants of the look-at view matrix block
`default_nettype none
package lav_pkg;

  localparam int INW  = 16;  // Q8.8 input field
  localparam int DW   = 17;  // eye - center, exact
  localparam int AXW  = 18;  // normalized axis component, signed Q2.16, |v| <= 1.0
  localparam int RAWW = 36;  // raw vector component before normalizing
  localparam int OUTW = 32;  // Q16.16 result field

  localparam logic [1:0]              ROW_LAST = 2'd3;
  localparam logic signed [OUTW-1:0]  ONE_Q16  = 32'sh0001_0000;

  // one queued request, difference already formed by the front
  typedef struct packed {
    logic signed [INW-1:0] eye_x;
    logic signed [INW-1:0] eye_y;
    logic signed [INW-1:0] eye_z;
    logic signed [DW-1:0]  d_x;
    logic signed [DW-1:0]  d_y;
    logic signed [DW-1:0]  d_z;
    logic signed [INW-1:0] up_x;
    logic signed [INW-1:0] up_y;
    logic signed [INW-1:0] up_z;
  } lav_item_t;

  // core to normalize unit
  typedef struct packed {
    logic                   start;
    logic signed [RAWW-1:0] v0;
    logic signed [RAWW-1:0] v1;
    logic signed [RAWW-1:0] v2;
  } lav_nreq_t;

  // normalize unit to core
  typedef struct packed {
    logic                  done;
    logic signed [AXW-1:0] u0;
    logic signed [AXW-1:0] u1;
    logic signed [AXW-1:0] u2;
  } lav_nrsp_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_TS, N_ROOT, N_DLOAD, N_DSTEP, N_DONE
  } lav_nst_t;

  typedef enum logic [3:0] {
    C_IDLE, C_ZGO, C_ZWAIT, C_CR1, C_XGO, C_XWAIT, C_CR2,
    C_YGO, C_YWAIT, C_DOT, C_EMIT
  } lav_cst_t;

endpackage
`default_nettype wire

// File: rtl/lav_if.sv
// request and row channel interfaces
`default_nettype none
interface lav_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] eye_x;
  logic signed [15:0] eye_y;
  logic signed [15:0] eye_z;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic signed [15:0] center_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;

  modport source (output valid, eye_x, eye_y, eye_z, center_x, center_y, center_z,
                  up_x, up_y, up_z, input ready);
  modport sink   (input valid, eye_x, eye_y, eye_z, center_x, center_y, center_z,
                  up_x, up_y, up_z, output ready);
endinterface

interface lav_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic signed [31:0] col0;
  logic signed [31:0] col1;
  logic signed [31:0] col2;
  logic signed [31:0] col3;
  logic               last_row;

  modport source (output valid, row_index, col0, col1, col2, col3, last_row,
                  input ready);
  modport sink   (input valid, row_index, col0, col1, col2, col3, last_row,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/lav_front.sv
// front: takes requests, forms eye - center, two-entry queue to the core
`default_nettype none
module lav_front import lav_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lav_in_if.sink     in_ch,
  input  wire logic  q_pop,
  output logic       q_valid,
  output lav_item_t  q_item
);

  lav_item_t  ent_r [2];
  lav_item_t  item_nxt;
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = ent_r[rp_r];

  always_comb begin
    item_nxt.eye_x = in_ch.eye_x;
    item_nxt.eye_y = in_ch.eye_y;
    item_nxt.eye_z = in_ch.eye_z;
    item_nxt.d_x   = DW'(in_ch.eye_x) - DW'(in_ch.center_x);
    item_nxt.d_y   = DW'(in_ch.eye_y) - DW'(in_ch.center_y);
    item_nxt.d_z   = DW'(in_ch.eye_z) - DW'(in_ch.center_z);
    item_nxt.up_x  = in_ch.up_x;
    item_nxt.up_y  = in_ch.up_y;
    item_nxt.up_z  = in_ch.up_z;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (q_pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= item_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/lav_norm.sv
// iterative vector normalize unit: scale, sum of squares, square root, divide
`default_nettype none
module lav_norm import lav_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire lav_nreq_t req,
  output lav_nrsp_t      rsp
);

  lav_nst_t              state_r, state_nxt;
  logic [RAWW-1:0]       a_r [3];
  logic [2:0]            neg_r;
  logic [1:0]            idx_r;
  logic [4:0]            cnt_r;
  logic [61:0]           prod_r;
  logic [63:0]           s_r;
  logic [4:0]            t_r;
  logic [63:0]           n_r, res_r;
  logic [32:0]           rem_r;
  logic [16:0]           lo_r, q_r;
  logic signed [AXW-1:0] u_r [3];

  logic [RAWW-1:0] a_or;
  logic            wide;
  logic [30:0]     sq_op;
  logic [63:0]     sq_sum;
  logic            ts_stop;
  logic [63:0]     bitv, rtrial;
  logic [30:0]     div_op;
  logic [5:0]      sh_amt;
  logic [48:0]     num;
  logic [32:0]     dtrial;
  logic            ge;
  logic [16:0]     q_fin;

  assign a_or    = a_r[0] | a_r[1] | a_r[2];
  assign wide    = (a_or[RAWW-1:31] != '0);
  assign sq_sum  = s_r + 64'(prod_r);
  assign ts_stop = (t_r == 5'd31) || (s_r[63:62] != 2'b00);
  assign bitv    = 64'(1) << {cnt_r, 1'b0};
  assign rtrial  = res_r + bitv;
  assign sh_amt  = 6'd16 + 6'(t_r);
  assign num     = (49'(div_op) << sh_amt) + 49'(res_r[31:1]);
  assign dtrial  = {rem_r[31:0], lo_r[16]};
  assign ge      = (dtrial >= {1'b0, res_r[31:0]});
  assign q_fin   = {q_r[15:0], ge};

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    sq_op = a_r[0][30:0];
      2'd1:    sq_op = a_r[1][30:0];
      2'd2:    sq_op = a_r[2][30:0];
      default: sq_op = '0;
    endcase
  end

  always_comb begin
    unique case (idx_r)
      2'd0:    div_op = a_r[0][30:0];
      2'd1:    div_op = a_r[1][30:0];
      2'd2:    div_op = a_r[2][30:0];
      default: div_op = '0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      N_IDLE:  if (req.start) state_nxt = N_SHIFT;
      N_SHIFT: if (!wide) state_nxt = N_SQ;
      N_SQ:    if (cnt_r == 5'd3) state_nxt = (sq_sum == '0) ? N_DONE : N_TS;
      N_TS:    if (ts_stop) state_nxt = N_ROOT;
      N_ROOT:  if (cnt_r == 5'd0) state_nxt = N_DLOAD;
      N_DLOAD: state_nxt = N_DSTEP;
      N_DSTEP: if (cnt_r == 5'd16) state_nxt = (idx_r == 2'd2) ? N_DONE : N_DLOAD;
      N_DONE:  state_nxt = N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = (state_r == N_DONE);
    rsp.u0   = u_r[0];
    rsp.u1   = u_r[1];
    rsp.u2   = u_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      N_IDLE: begin
        neg_r  <= {req.v2[RAWW-1], req.v1[RAWW-1], req.v0[RAWW-1]};
        a_r[0] <= req.v0[RAWW-1] ? $unsigned(-req.v0) : $unsigned(req.v0);
        a_r[1] <= req.v1[RAWW-1] ? $unsigned(-req.v1) : $unsigned(req.v1);
        a_r[2] <= req.v2[RAWW-1] ? $unsigned(-req.v2) : $unsigned(req.v2);
        cnt_r  <= '0;
      end
      N_SHIFT: begin
        if (wide) begin
          a_r[0] <= a_r[0] >> 1;
          a_r[1] <= a_r[1] >> 1;
          a_r[2] <= a_r[2] >> 1;
        end
        cnt_r <= '0;
      end
      N_SQ: begin
        prod_r <= sq_op * sq_op;
        s_r    <= (cnt_r == 5'd0) ? '0 : sq_sum;
        cnt_r  <= cnt_r + 5'd1;
        t_r    <= '0;
        if (cnt_r == 5'd3 && sq_sum == '0) begin
          u_r[0] <= '0;
          u_r[1] <= '0;
          u_r[2] <= '0;
        end
      end
      N_TS: begin
        if (!ts_stop) begin
          s_r <= s_r << 2;
          t_r <= t_r + 5'd1;
        end
        n_r   <= s_r;
        res_r <= '0;
        cnt_r <= 5'd31;
      end
      N_ROOT: begin
        if (n_r >= rtrial) begin
          n_r   <= n_r - rtrial;
          res_r <= (res_r >> 1) + bitv;
        end else begin
          res_r <= res_r >> 1;
        end
        cnt_r <= cnt_r - 5'd1;
        idx_r <= '0;
      end
      N_DLOAD: begin
        rem_r <= {1'b0, num[48:17]};
        lo_r  <= num[16:0];
        cnt_r <= '0;
      end
      N_DSTEP: begin
        rem_r <= ge ? (dtrial - {1'b0, res_r[31:0]}) : dtrial;
        lo_r  <= lo_r << 1;
        q_r   <= q_fin;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd16) begin
          u_r[idx_r] <= neg_r[idx_r] ? -$signed(AXW'(q_fin)) : $signed(AXW'(q_fin));
          idx_r      <= idx_r + 2'd1;
        end
      end
      N_DONE: begin
        cnt_r <= '0;
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/lav_core.sv
// back end: sequences normalizes, cross and dot products, emits four rows
`default_nettype none
module lav_core import lav_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_valid,
  input  wire lav_item_t q_item,
  output logic           q_pop,
  output lav_nreq_t      nreq,
  input  wire lav_nrsp_t nrsp,
  lav_out_if.source      out_ch
);

  localparam int SW = RAWW + 1;

  lav_cst_t                state_r, state_nxt;
  lav_item_t               it_r;
  logic signed [AXW-1:0]   ax_r [3][3];
  logic [3:0]              j_r;
  logic signed [RAWW-1:0]  prod_r;
  logic [1:0]              ptgt_r;
  logic                    psub_r, pval_r;
  logic signed [RAWW-1:0]  acc_r [3];
  logic [1:0]              row_r;

  logic                    ov_r, olast_r;
  logic [1:0]              orow_r;
  logic signed [OUTW-1:0]  oc0_r, oc1_r, oc2_r, oc3_r;

  logic signed [AXW-1:0]   p0, p1, p2, q0, q1, q2;
  logic signed [AXW-1:0]   e0, e1, e2;
  logic signed [AXW-1:0]   op_a, op_b;
  logic signed [RAWW-1:0]  mul;
  logic [1:0]              tgt;
  logic                    sub, fire;
  logic                    load;
  logic signed [OUTW-1:0]  r_c0, r_c1, r_c2, r_c3;

  function automatic logic signed [OUTW-1:0] trans(input logic signed [RAWW-1:0] dot);
    logic [RAWW-1:0]        m;
    logic [SW-1:0]          s;
    logic signed [OUTW-1:0] qs;
    m  = dot[RAWW-1] ? $unsigned(-dot) : $unsigned(dot);
    s  = {1'b0, m} + SW'(128);
    // magnitude stays below 2^28, so the clamp to 32 bits never engages
    qs = $signed(OUTW'(s[SW-1:8]));
    return dot[RAWW-1] ? qs : -qs;
  endfunction

  assign e0 = AXW'(it_r.eye_x);
  assign e1 = AXW'(it_r.eye_y);
  assign e2 = AXW'(it_r.eye_z);

  // cross operands: up x z, then z x x
  always_comb begin
    if (state_r == C_CR1) begin
      p0 = AXW'(it_r.up_x);
      p1 = AXW'(it_r.up_y);
      p2 = AXW'(it_r.up_z);
      q0 = ax_r[2][0];
      q1 = ax_r[2][1];
      q2 = ax_r[2][2];
    end else begin
      p0 = ax_r[2][0];
      p1 = ax_r[2][1];
      p2 = ax_r[2][2];
      q0 = ax_r[0][0];
      q1 = ax_r[0][1];
      q2 = ax_r[0][2];
    end
  end

  // one product a cycle through the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    tgt  = 2'd0;
    sub  = 1'b0;
    fire = 1'b0;
    if (state_r == C_CR1 || state_r == C_CR2) begin
      fire = (j_r < 4'd6);
      unique case (j_r)
        4'd0:    begin op_a = p1; op_b = q2; tgt = 2'd0; end
        4'd1:    begin op_a = p2; op_b = q1; tgt = 2'd0; sub = 1'b1; end
        4'd2:    begin op_a = p2; op_b = q0; tgt = 2'd1; end
        4'd3:    begin op_a = p0; op_b = q2; tgt = 2'd1; sub = 1'b1; end
        4'd4:    begin op_a = p0; op_b = q1; tgt = 2'd2; end
        4'd5:    begin op_a = p1; op_b = q0; tgt = 2'd2; sub = 1'b1; end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end else if (state_r == C_DOT) begin
      fire = (j_r < 4'd9);
      unique case (j_r)
        4'd0:    begin op_a = ax_r[0][0]; op_b = e0; tgt = 2'd0; end
        4'd1:    begin op_a = ax_r[0][1]; op_b = e1; tgt = 2'd0; end
        4'd2:    begin op_a = ax_r[0][2]; op_b = e2; tgt = 2'd0; end
        4'd3:    begin op_a = ax_r[1][0]; op_b = e0; tgt = 2'd1; end
        4'd4:    begin op_a = ax_r[1][1]; op_b = e1; tgt = 2'd1; end
        4'd5:    begin op_a = ax_r[1][2]; op_b = e2; tgt = 2'd1; end
        4'd6:    begin op_a = ax_r[2][0]; op_b = e0; tgt = 2'd2; end
        4'd7:    begin op_a = ax_r[2][1]; op_b = e1; tgt = 2'd2; end
        4'd8:    begin op_a = ax_r[2][2]; op_b = e2; tgt = 2'd2; end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end
  end

  assign mul = op_a * op_b;

  // row payload
  always_comb begin
    r_c0 = '0;
    r_c1 = '0;
    r_c2 = '0;
    r_c3 = ONE_Q16;
    unique case (row_r)
      2'd0: begin
        r_c0 = OUTW'(ax_r[0][0]); r_c1 = OUTW'(ax_r[0][1]); r_c2 = OUTW'(ax_r[0][2]);
        r_c3 = trans(acc_r[0]);
      end
      2'd1: begin
        r_c0 = OUTW'(ax_r[1][0]); r_c1 = OUTW'(ax_r[1][1]); r_c2 = OUTW'(ax_r[1][2]);
        r_c3 = trans(acc_r[1]);
      end
      2'd2: begin
        r_c0 = OUTW'(ax_r[2][0]); r_c1 = OUTW'(ax_r[2][1]); r_c2 = OUTW'(ax_r[2][2]);
        r_c3 = trans(acc_r[2]);
      end
      default: begin
        r_c3 = ONE_Q16;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE:  if (q_valid) state_nxt = C_ZGO;
      C_ZGO:   state_nxt = C_ZWAIT;
      C_ZWAIT: if (nrsp.done) state_nxt = C_CR1;
      C_CR1:   if (j_r == 4'd6) state_nxt = C_XGO;
      C_XGO:   state_nxt = C_XWAIT;
      C_XWAIT: if (nrsp.done) state_nxt = C_CR2;
      C_CR2:   if (j_r == 4'd6) state_nxt = C_YGO;
      C_YGO:   state_nxt = C_YWAIT;
      C_YWAIT: if (nrsp.done) state_nxt = C_DOT;
      C_DOT:   if (j_r == 4'd9) state_nxt = C_EMIT;
      C_EMIT:  if (load && row_r == ROW_LAST) state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop      = (state_r == C_IDLE) && q_valid;
    load       = (state_r == C_EMIT) && (!ov_r || out_ch.ready);
    nreq.start = (state_r == C_ZGO) || (state_r == C_XGO) || (state_r == C_YGO);
    if (state_r == C_ZGO) begin
      nreq.v0 = RAWW'(it_r.d_x);
      nreq.v1 = RAWW'(it_r.d_y);
      nreq.v2 = RAWW'(it_r.d_z);
    end else begin
      nreq.v0 = acc_r[0];
      nreq.v1 = acc_r[1];
      nreq.v2 = acc_r[2];
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.row_index = orow_r;
  assign out_ch.col0      = oc0_r;
  assign out_ch.col1      = oc1_r;
  assign out_ch.col2      = oc2_r;
  assign out_ch.col3      = oc3_r;
  assign out_ch.last_row  = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      ov_r    <= 1'b0;
      pval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pval_r  <= fire;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      it_r  <= q_item;
      row_r <= '0;
    end
    prod_r <= mul;
    ptgt_r <= tgt;
    psub_r <= sub;
    if (state_r == C_CR1 || state_r == C_CR2 || state_r == C_DOT) begin
      j_r <= j_r + 4'd1;
      if (j_r == 4'd0) begin
        acc_r[0] <= '0;
        acc_r[1] <= '0;
        acc_r[2] <= '0;
      end else if (pval_r) begin
        acc_r[ptgt_r] <= psub_r ? (acc_r[ptgt_r] - prod_r) : (acc_r[ptgt_r] + prod_r);
      end
    end else begin
      j_r <= '0;
    end
    if (nrsp.done) begin
      unique case (state_r)
        C_ZWAIT: begin ax_r[2][0] <= nrsp.u0; ax_r[2][1] <= nrsp.u1; ax_r[2][2] <= nrsp.u2; end
        C_XWAIT: begin ax_r[0][0] <= nrsp.u0; ax_r[0][1] <= nrsp.u1; ax_r[0][2] <= nrsp.u2; end
        C_YWAIT: begin ax_r[1][0] <= nrsp.u0; ax_r[1][1] <= nrsp.u1; ax_r[1][2] <= nrsp.u2; end
        default: begin end
      endcase
    end
    if (load) begin
      orow_r  <= row_r;
      oc0_r   <= r_c0;
      oc1_r   <= r_c1;
      oc2_r   <= r_c2;
      oc3_r   <= r_c3;
      olast_r <= (row_r == ROW_LAST);
      row_r   <= row_r + 2'd1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/look_at_view_matrix.sv
// top level of the look-at view matrix block
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+------------------------------------------
//  in_ch   | in  | valid / ready   | eye, center, up (9 x signed Q8.8)
//  out_ch  | out | valid / ready   | row_index, col0..col3 (Q16.16), last_row
//
// each request yields four rows, row 0 first; a request finishes sooner when an axis
// has zero length, and soonest when all three vanish
// the normalize unit runs three passes per request, each a bit-serial 64-bit square root
//   and three 17-step restoring divides, plus a scale-search of 1 to 32
// synchronous active-low reset clears the queue, sequencers and output valid
// the front queue holds two requests, so the next ones are taken while rows wait
// a stalled out_ch holds its row; the core waits only at the output register
`default_nettype none
module look_at_view_matrix import lav_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  lav_in_if.sink    in_ch,
  lav_out_if.source out_ch
);

  logic      q_valid;
  logic      q_pop;
  lav_item_t q_item;
  lav_nreq_t nreq;
  lav_nrsp_t nrsp;

  // front: accept, form eye - center, queue
  lav_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  // shared normalize unit for the z, x and y axes
  lav_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nreq),
    .rsp   (nrsp)
  );

  // back end: sequencing, cross and dot products, row output register
  lav_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .nreq    (nreq),
    .nrsp    (nrsp),
    .out_ch  (out_ch)
  );

`ifndef SYNTH
  // the last row is the constant bottom row
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_row |->
      out_ch.row_index == ROW_LAST && out_ch.col0 == '0 && out_ch.col3 == ONE_Q16)
    else $error("last row malformed");

  // a taken request is visible to the core on the next cycle
  a_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> q_valid)
    else $error("queued request lost");

  // rows of one request follow without a gap once the consumer takes them
  a_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_row |=>
      out_ch.valid && out_ch.row_index == 2'($past(out_ch.row_index) + 2'd1))
    else $error("row sequence broken");

  // the normalize unit is started only from the core's issue states, never back to back
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    nreq.start |=> !nreq.start)
    else $error("back-to-back normalize start");
`endif

endmodule
`default_nettype wire

// File: test/tb_look_at_view_matrix.sv
// self-checking testbench of the look-at view matrix block
`default_nettype none
module tb_look_at_view_matrix import lav_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // one pending request as the driver sends it
  typedef struct {
    logic signed [15:0] eye [3];
    logic signed [15:0] ctr [3];
    logic signed [15:0] up [3];
  } view_req_t;

  // one matrix row as the block should return it
  typedef struct {
    logic [1:0]         row;
    logic signed [31:0] c [4];
    logic               last;
  } mat_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lav_in_if  in_ch ();
  lav_out_if out_ch ();

  look_at_view_matrix u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  view_req_t pending_reqs[$];
  mat_row_t  rows_due[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_send = 1'b0;
  int  errors = 0;
  int  reqs_sent = 0;
  int  rows_seen = 0;
  int  quiet_cycles = 0;

  // ---------------------------------------------------------------- prediction

  function automatic longint isqrt_u64(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // scale a raw vector to unit length in Q16.16, zero vector stays zero
  task automatic to_unit(input longint v [3], output longint u [3]);
    longint unsigned a [3], r [3], s, m, mag, q;
    bit              neg [3];
    int              k, t;
    s = 0;
    k = 0;
    t = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      a[i] = neg[i] ? -v[i] : v[i];
    end
    m = a[0] | a[1] | a[2];
    while (k < 63 && ((m >> k) >> 31) != 0) k++;
    for (int i = 0; i < 3; i++) begin
      r[i] = a[i] >> k;
      s += r[i] * r[i];
    end
    if (s == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
      return;
    end
    while (t < 31 && s < (64'd1 << (62 - 2 * t))) t++;
    mag = isqrt_u64(s << (2 * t));
    for (int i = 0; i < 3; i++) begin
      q = ((r[i] << (16 + t)) + mag / 2) / mag;
      u[i] = neg[i] ? -longint'(q) : longint'(q);
    end
  endtask

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  task automatic cross_of(input longint p [3], input longint q [3],
                          output longint o [3]);
    o[0] = p[1] * q[2] - p[2] * q[1];
    o[1] = p[2] * q[0] - p[0] * q[2];
    o[2] = p[0] * q[1] - p[1] * q[0];
  endtask

  // build the four rows of the view matrix for one request
  task automatic predict_view(input view_req_t rq);
    longint   eye [3], d [3], up [3], raw [3], ax [3][3], zx [3], xx [3], yx [3];
    longint   dot, na;
    mat_row_t mr;
    for (int i = 0; i < 3; i++) begin
      eye[i] = rq.eye[i];
      d[i] = longint'(rq.eye[i]) - longint'(rq.ctr[i]);
      up[i] = rq.up[i];
    end
    to_unit(d, zx);
    cross_of(up, zx, raw);
    to_unit(raw, xx);
    cross_of(zx, xx, raw);
    to_unit(raw, yx);
    ax[0] = xx; ax[1] = yx; ax[2] = zx;
    for (int r = 0; r < 3; r++) begin
      dot = ax[r][0] * eye[0] + ax[r][1] * eye[1] + ax[r][2] * eye[2];
      // negate, then divide by 256 with ties away from zero
      na = ((dot > 0 ? dot : -dot) + 128) / 256;
      mr.row = r[1:0];
      for (int c = 0; c < 3; c++) mr.c[c] = clamp32(ax[r][c]);
      mr.c[3] = clamp32(dot > 0 ? -na : na);
      mr.last = 1'b0;
      rows_due.push_back(mr);
    end
    mr.row = ROW_LAST;
    mr.c[0] = 0; mr.c[1] = 0; mr.c[2] = 0;
    mr.c[3] = ONE_Q16;
    mr.last = 1'b1;
    rows_due.push_back(mr);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // previous request accepted or none out, pick the next one
      if (in_ch.valid) begin
        predict_view(pending_reqs.pop_front());
        reqs_sent++;
      end
      if (pending_reqs.size() != 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid    <= 1'b1;
        in_ch.eye_x    <= pending_reqs[0].eye[0];
        in_ch.eye_y    <= pending_reqs[0].eye[1];
        in_ch.eye_z    <= pending_reqs[0].eye[2];
        in_ch.center_x <= pending_reqs[0].ctr[0];
        in_ch.center_y <= pending_reqs[0].ctr[1];
        in_ch.center_z <= pending_reqs[0].ctr[2];
        in_ch.up_x     <= pending_reqs[0].up[0];
        in_ch.up_y     <= pending_reqs[0].up[1];
        in_ch.up_z     <= pending_reqs[0].up[2];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        mat_row_t want;
        rows_seen++;
        if (rows_due.size() == 0) begin
          $display("%0t: row %0d with no request pending", $time, out_ch.row_index);
          errors++;
        end else begin
          want = rows_due.pop_front();
          if (out_ch.row_index !== want.row || out_ch.last_row !== want.last ||
              out_ch.col0 !== want.c[0] || out_ch.col1 !== want.c[1] ||
              out_ch.col2 !== want.c[2] || out_ch.col3 !== want.c[3]) begin
            $display("%0t: expected row %0d %h %h %h %h last %b", $time, want.row,
                     want.c[0], want.c[1], want.c[2], want.c[3], want.last);
            $display("%0t: actual   row %0d %h %h %h %h last %b", $time,
                     out_ch.row_index, out_ch.col0, out_ch.col1, out_ch.col2,
                     out_ch.col3, out_ch.last_row);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: fails the run once the quiet counter passes its limit with no handshake on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [15:0] rand_field(int mode);
    case (mode)
      0: return $urandom_range(65535);
      1: return $signed(16'($urandom_range(511))) - 16'sd256; // near origin
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return $signed(16'($urandom_range(31)));
    endcase
  endfunction

  task automatic add_req(input logic signed [15:0] e [3], input logic signed [15:0] c [3],
                         input logic signed [15:0] u [3]);
    view_req_t rq;
    rq.eye = e;
    rq.ctr = c;
    rq.up  = u;
    pending_reqs.push_back(rq);
  endtask

  task automatic add_random(int n);
    logic signed [15:0] e [3], c [3], u [3];
    int mode;
    repeat (n) begin
      mode = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
        e[i] = rand_field(mode < 6 ? 0 : mode - 6);
        c[i] = rand_field(mode < 6 ? 0 : mode - 6);
        u[i] = rand_field(mode < 6 ? 0 : mode - 6);
      end
      // some degenerate cases: eye on target, zero up, up along forward
      case ($urandom_range(19))
        0: c = e;
        1: begin u[0] = 0; u[1] = 0; u[2] = 0; end
        2: for (int i = 0; i < 3; i++) u[i] = e[i] - c[i];
        default: ;
      endcase
      add_req(e, c, u);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_ch.valid || rows_due.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] e [3], c [3], u [3];
    in_ch.valid = 1'b0;
    in_ch.eye_x = 0; in_ch.eye_y = 0; in_ch.eye_z = 0;
    in_ch.center_x = 0; in_ch.center_y = 0; in_ch.center_z = 0;
    in_ch.up_x = 0; in_ch.up_y = 0; in_ch.up_z = 0;
    out_ch.ready = 1'b0;

    // directed: plain camera, extremes, zero-length cases
    e = '{16'sh0000, 16'sh0000, 16'sh0500}; c = '{0, 0, 0}; u = '{0, 16'sh0100, 0};
    add_req(e, c, u);
    e = '{16'sh7fff, 16'sh7fff, 16'sh7fff}; c = '{16'sh8000, 16'sh8000, 16'sh8000};
    u = '{16'sh7fff, 16'sh8000, 16'sh7fff};
    add_req(e, c, u);
    e = '{16'sh8000, 16'sh8000, 16'sh8000}; c = '{16'sh7fff, 16'sh7fff, 16'sh7fff};
    u = '{16'sh8000, 16'sh7fff, 16'sh8000};
    add_req(e, c, u);
    e = '{16'sh1234, -16'sh0100, 16'sh0777}; c = e; u = '{0, 16'sh0100, 0};
    add_req(e, c, u);                                   // eye on target
    e = '{16'sh0100, 16'sh0200, 16'sh0300}; c = '{0, 0, 0}; u = '{0, 0, 0};
    add_req(e, c, u);                                   // zero up
    u = '{16'sh0200, 16'sh0400, 16'sh0600};
    add_req(e, c, u);                                   // up parallel to forward
    e = '{16'sh0001, 0, 0}; c = '{0, 0, 0}; u = '{0, 0, 16'sh0001};
    add_req(e, c, u);                                   // tiny vectors
    e = '{16'sh7fff, 16'sh8000, 16'sh0000}; c = '{16'sh8000, 16'sh7fff, 16'sh7fff};
    u = '{16'shffff, 16'sh5555, 16'shaaaa};
    add_req(e, c, u);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 13; recv_idle_pct = 71;
    add_random(150);
    wait_drained();

    // sender holds off mid-stream until all rows are back
    add_random(20);
    repeat (50) @(posedge clk);
    hold_send = 1'b1;
    while (in_ch.valid || rows_due.size() != 0)
      @(posedge clk);
    hold_send = 1'b0;
    wait_drained();

    send_idle_pct = 71; recv_idle_pct = 13;
    add_random(150);
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    add_random(150);
    wait_drained();
    repeat (600) @(posedge clk);

    $display("covered %0d view requests, %0d matrix rows checked, %0d errors",
             reqs_sent, rows_seen, errors);
    if (errors == 0 && rows_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
